// ===== hw/rtl/prds_pkg.sv =====
package prds_pkg;

    typedef enum logic [1:0] {
        OP_ADMIT   = 2'd0,
        OP_RELEASE = 2'd1,
        OP_SETPRI  = 2'd2,
        OP_GETPRI  = 2'd3
    } op_t;

    localparam logic [1:0] TAG_NONE  = 2'd0;
    localparam logic [1:0] TAG_READY = 2'd1;
    localparam logic [1:0] TAG_DONE  = 2'd2;

    localparam logic [1:0] RUN_STOPPED = 2'd0;
    localparam logic [1:0] RUN_READY   = 2'd1;
    localparam logic [1:0] RUN_RUNNING = 2'd2;

    localparam int LEVELS = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture request fields
        logic park;       // put running task on done queue
        logic pop;        // pop lowest-numbered non-empty ready level
        logic swap;       // done set becomes ready set
        logic finish;     // commit release result
        logic single;     // admit, set or get in one step
    } prds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic ready_any;  // some ready queue is non-empty
        logic is_release;
    } prds_stat_t;

endpackage

// ===== hw/rtl/priority_ready_done_scheduler_top.sv =====
// Four-level priority task scheduler over a table of PROCESS_COUNT tasks.
// Requests enter on the s_ channel (s_operation, s_pid, s_priority_req)
// under s_valid/s_ready; each request yields exactly one result on the
// m_ channel (m_status, m_pid_out, m_priority_out, m_first_start) under
// m_valid/m_ready.
// Admit, set priority and get priority have their result registered in the
// cycle after acceptance: the fields are captured at acceptance, and the
// next cycle decodes them, updates the tables and loads the result.
// A release passes through dispatch, parking of the running task, queue pop
// and result; when every ready queue is empty the done set is first swapped
// in and the search repeated. The controller walks one request at a time, so
// a new request is not taken until the last result is in the output register.
// After the synchronous active-low reset every queue is empty, no task is
// running and all priorities are zero; no clearing pass is needed as the
// tables sit in flip-flops.
// When the receiver stalls the result is held in the output register and
// a new request is not taken until that result has been collected.
module priority_ready_done_scheduler_top #(
    parameter int PROCESS_COUNT = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_operation,
    input  logic [5:0] s_pid,
    input  logic [1:0] s_priority_req,
    output logic       m_valid,
    input  logic       m_ready,
    output logic       m_status,
    output logic [5:0] m_pid_out,
    output logic [1:0] m_priority_out,
    output logic       m_first_start
);
    import prds_pkg::*;

    prds_cmd_t  cmd;
    prds_stat_t stat;

    // The controller sequences each request; the datapath owns the tables.
    prds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    prds_dp #(
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_operation    (s_operation),
        .s_pid          (s_pid),
        .s_priority_req (s_priority_req),
        .cmd            (cmd),
        .stat           (stat),
        .m_status       (m_status),
        .m_pid_out      (m_pid_out),
        .m_priority_out (m_priority_out),
        .m_first_start  (m_first_start)
    );
endmodule

// ===== hw/rtl/prds_ctrl.sv =====
module prds_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  prds_pkg::prds_stat_t  stat,
    output prds_pkg::prds_cmd_t   cmd
);
    import prds_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DISP  = 6'b000010,
        ST_PARK  = 6'b000100,
        ST_POP   = 6'b001000,
        ST_SWAP  = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   swapped_reg, swapped_next;

    assign s_ready = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        swapped_next   = swapped_reg;
        cmd            = '0;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (stat.is_release) begin
                    state_next = ST_PARK;
                end else begin
                    cmd.single     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_PARK: begin
                cmd.park     = 1'b1;
                swapped_next = 1'b0;
                state_next   = ST_POP;
            end
            ST_POP: begin
                if (stat.ready_any || swapped_reg) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SWAP;
                end
            end
            ST_SWAP: begin
                cmd.swap     = 1'b1;
                swapped_next = 1'b1;
                state_next   = ST_POP;
            end
            ST_OUT: begin
                cmd.finish     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            swapped_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            swapped_reg   <= swapped_next;
        end
    end
endmodule

// ===== hw/rtl/prds_dp.sv =====
module prds_dp #(
    parameter int PROCESS_COUNT = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [1:0]            s_operation,
    input  logic [5:0]            s_pid,
    input  logic [1:0]            s_priority_req,
    input  prds_pkg::prds_cmd_t   cmd,
    output prds_pkg::prds_stat_t  stat,
    output logic                  m_status,
    output logic [5:0]            m_pid_out,
    output logic [1:0]            m_priority_out,
    output logic                  m_first_start
);
    import prds_pkg::*;

    localparam int TW = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
    localparam int NQ = 2 * LEVELS;

    // Links carry a valid flag in the top bit.
    typedef logic [TW:0] link_t;

    logic [1:0] pri_reg  [PROCESS_COUNT];
    logic [1:0] tag_reg  [PROCESS_COUNT];
    logic [1:0] run_reg  [PROCESS_COUNT];
    link_t      nxt_reg  [PROCESS_COUNT];
    link_t      prv_reg  [PROCESS_COUNT];
    link_t      head_reg [NQ];
    link_t      tail_reg [NQ];
    link_t      cur_reg;

    logic [1:0] op_reg;
    logic [5:0] pid_reg;
    logic [1:0] preq_reg;
    link_t      pick_reg;

    logic       st_reg;
    logic [5:0] po_reg;
    logic [1:0] pr_reg;
    logic       fs_reg;

    assign m_status       = st_reg;
    assign m_pid_out      = po_reg;
    assign m_priority_out = pr_reg;
    assign m_first_start  = fs_reg;

    function automatic logic s_pid_ok(input logic [5:0] p);
        return {26'd0, p} < 32'(PROCESS_COUNT);
    endfunction

    logic pid_ok;
    logic [TW-1:0] pt;
    assign pid_ok = s_pid_ok(pid_reg);
    assign pt     = pid_reg[TW-1:0];

    always_comb begin
        stat.is_release = (op_t'(op_reg) == OP_RELEASE);
        stat.ready_any  = 1'b0;
        for (int l = 0; l < LEVELS; l++) begin
            stat.ready_any = stat.ready_any | head_reg[l][TW];
        end
    end

    // Lowest-numbered non-empty ready level, the one served first.
    logic [1:0] plev;
    link_t      phead;
    always_comb begin
        plev = 2'd0;
        for (int l = LEVELS - 1; l >= 0; l--) begin
            if (head_reg[l][TW]) begin
                plev = 2'(l);
            end
        end
        phead = head_reg[{1'b0, plev}];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= s_operation;
            pid_reg  <= s_pid;
            preq_reg <= s_priority_req;
        end
    end

    // Table updates; the temporaries model the sequential link edits.
    always_ff @(posedge aclk) begin
        logic [2:0]    q, qo;
        link_t         tl, n, p;
        logic [TW-1:0] t;
        if (!aresetn) begin
            for (int i = 0; i < PROCESS_COUNT; i++) begin
                pri_reg[i] <= 2'd0;
                tag_reg[i] <= TAG_NONE;
                run_reg[i] <= RUN_STOPPED;
                nxt_reg[i] <= '0;
                prv_reg[i] <= '0;
            end
            for (int i = 0; i < NQ; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            cur_reg  <= '0;
            pick_reg <= '0;
        end else begin
            if (cmd.park) begin
                pick_reg <= '0;
                if (cur_reg[TW]) begin
                    t  = cur_reg[TW-1:0];
                    q  = {1'b1, pri_reg[t]};
                    tl = tail_reg[q];
                    nxt_reg[t] <= '0;
                    if (tl[TW]) begin
                        prv_reg[t] <= tl;
                        nxt_reg[tl[TW-1:0]] <= {1'b1, t};
                    end else begin
                        prv_reg[t] <= '0;
                        head_reg[q] <= {1'b1, t};
                    end
                    tail_reg[q] <= {1'b1, t};
                    tag_reg[t]  <= TAG_DONE;
                    run_reg[t]  <= RUN_READY;
                end
            end
            if (cmd.swap) begin
                for (int l = 0; l < LEVELS; l++) begin
                    head_reg[l] <= head_reg[l + LEVELS];
                    tail_reg[l] <= tail_reg[l + LEVELS];
                    head_reg[l + LEVELS] <= '0;
                    tail_reg[l + LEVELS] <= '0;
                end
                for (int i = 0; i < PROCESS_COUNT; i++) begin
                    if (tag_reg[i] == TAG_DONE) begin
                        tag_reg[i] <= TAG_READY;
                    end
                end
            end
            if (cmd.pop) begin
                pick_reg <= phead;
                if (phead[TW]) begin
                    t = phead[TW-1:0];
                    q = {1'b0, plev};
                    n = nxt_reg[t];
                    head_reg[q] <= n[TW] ? n : '0;
                    if (n[TW]) begin
                        prv_reg[n[TW-1:0]] <= '0;
                    end else begin
                        tail_reg[q] <= '0;
                    end
                    nxt_reg[t] <= '0;
                    prv_reg[t] <= '0;
                    tag_reg[t] <= TAG_NONE;
                end
            end
            if (cmd.finish) begin
                cur_reg <= pick_reg;
                if (pick_reg[TW]) begin
                    run_reg[pick_reg[TW-1:0]] <= RUN_RUNNING;
                end
            end
            if (cmd.single && pid_ok) begin
                case (op_t'(op_reg))
                    OP_ADMIT: begin
                        if (tag_reg[pt] == TAG_NONE && cur_reg != {1'b1, pt}) begin
                            q  = {1'b0, preq_reg};
                            tl = tail_reg[q];
                            pri_reg[pt] <= preq_reg;
                            run_reg[pt] <= RUN_STOPPED;
                            nxt_reg[pt] <= '0;
                            if (tl[TW]) begin
                                prv_reg[pt] <= tl;
                                nxt_reg[tl[TW-1:0]] <= {1'b1, pt};
                            end else begin
                                prv_reg[pt] <= '0;
                                head_reg[q] <= {1'b1, pt};
                            end
                            tail_reg[q] <= {1'b1, pt};
                            tag_reg[pt] <= TAG_READY;
                        end
                    end
                    OP_SETPRI: begin
                        if (pid_reg != 6'd0) begin
                            pri_reg[pt] <= preq_reg;
                            if (cur_reg != {1'b1, pt} && tag_reg[pt] != TAG_NONE) begin
                                qo = {tag_reg[pt] == TAG_DONE, pri_reg[pt]};
                                q  = {tag_reg[pt] == TAG_DONE, preq_reg};
                                n  = nxt_reg[pt];
                                p  = prv_reg[pt];
                                if (p[TW] && qo != q) begin
                                    nxt_reg[p[TW-1:0]] <= n;
                                end
                                // Removal from the old queue.
                                if (!p[TW]) head_reg[qo] <= n[TW] ? n : '0;
                                else if (qo != q || 1'b1) nxt_reg[p[TW-1:0]] <= n;
                                if (n[TW]) prv_reg[n[TW-1:0]] <= p;
                                else tail_reg[qo] <= p[TW] ? p : '0;
                                // Append to the new queue, after removal.
                                tl = (qo == q) ? (n[TW] ? tail_reg[q] : p)
                                               : tail_reg[q];
                                nxt_reg[pt] <= '0;
                                if (tl[TW]) begin
                                    prv_reg[pt] <= tl;
                                    nxt_reg[tl[TW-1:0]] <= {1'b1, pt};
                                    if (qo == q && !p[TW] && !n[TW]) begin
                                        head_reg[q] <= {1'b1, pt};
                                    end
                                end else begin
                                    prv_reg[pt] <= '0;
                                    head_reg[q] <= {1'b1, pt};
                                end
                                if (qo == q && !n[TW] && p[TW]) begin
                                    nxt_reg[p[TW-1:0]] <= {1'b1, pt};
                                end
                                tail_reg[q] <= {1'b1, pt};
                                if (qo == q && n[TW] && !p[TW]) begin
                                    head_reg[q] <= n;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.single) begin
            st_reg <= 1'b1;
            po_reg <= pid_reg;
            pr_reg <= 2'd0;
            fs_reg <= 1'b0;
            if (pid_ok) begin
                case (op_t'(op_reg))
                    OP_ADMIT: begin
                        if (tag_reg[pt] == TAG_NONE && cur_reg != {1'b1, pt}) begin
                            st_reg <= 1'b0;
                            pr_reg <= preq_reg;
                        end
                    end
                    OP_SETPRI: begin
                        if (pid_reg != 6'd0) begin
                            st_reg <= 1'b0;
                            pr_reg <= preq_reg;
                        end
                    end
                    OP_GETPRI: begin
                        st_reg <= 1'b0;
                        pr_reg <= pri_reg[pt];
                    end
                    default: begin
                    end
                endcase
            end
        end else if (cmd.finish) begin
            fs_reg <= 1'b0;
            if (pick_reg[TW]) begin
                st_reg <= 1'b0;
                po_reg <= 6'(pick_reg[TW-1:0]);
                pr_reg <= pri_reg[pick_reg[TW-1:0]];
                fs_reg <= (run_reg[pick_reg[TW-1:0]] == RUN_STOPPED);
            end else begin
                st_reg <= 1'b1;
                po_reg <= pid_reg;
                pr_reg <= 2'd0;
            end
        end
    end
endmodule

// ===== verif/prds_checker.sv =====
module prds_checker #(
    parameter int PROCESS_COUNT = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [5:0]  s_pid,
    input  logic [1:0]  s_priority_req,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_status,
    input  logic [5:0]  m_pid_out,
    input  logic [1:0]  m_priority_out,
    input  logic        m_first_start,
    output int          fail_count,
    output int          pending
);
    import prds_pkg::*;

    localparam int NIL = 255;

    typedef struct packed {
        logic       status;
        logic [5:0] pid;
        logic [1:0] prio;
        logic       first;
    } sched_result_t;

    // Shadow copy of the scheduler tables.
    logic [1:0] prio_tab [PROCESS_COUNT];
    logic [1:0] tag_tab  [PROCESS_COUNT];
    logic [1:0] run_tab  [PROCESS_COUNT];
    int         nxt      [PROCESS_COUNT];
    int         prv      [PROCESS_COUNT];
    int         head     [2*LEVELS];
    int         tail     [2*LEVELS];
    int         running;

    sched_result_t awaited_results[$];

    function automatic bit valid_task(int t);
        return t >= 0 && t < PROCESS_COUNT;
    endfunction

    function automatic void queue_task(int set, int t);
        int q;
        q = set * LEVELS + prio_tab[t];
        nxt[t] = NIL;
        if (valid_task(tail[q])) begin
            prv[t] = tail[q];
            nxt[tail[q]] = t;
        end else begin
            prv[t] = NIL;
            head[q] = t;
        end
        tail[q] = t;
        tag_tab[t] = (set == 0) ? TAG_READY : TAG_DONE;
    endfunction

    function automatic void dequeue_task(int t);
        int q, n, p;
        q = ((tag_tab[t] == TAG_DONE) ? LEVELS : 0) + prio_tab[t];
        n = nxt[t];
        p = prv[t];
        if (valid_task(p)) nxt[p] = n;
        else head[q] = valid_task(n) ? n : NIL;
        if (valid_task(n)) prv[n] = p;
        else tail[q] = valid_task(p) ? p : NIL;
        nxt[t] = NIL;
        prv[t] = NIL;
        tag_tab[t] = TAG_NONE;
    endfunction

    function automatic int take_highest_ready();
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (valid_task(head[lv])) begin
                int h;
                h = head[lv];
                dequeue_task(h);
                return h;
            end
        end
        return NIL;
    endfunction

    function automatic void clear_tables();
        for (int i = 0; i < PROCESS_COUNT; i++) begin
            prio_tab[i] = 0;
            tag_tab[i] = TAG_NONE;
            run_tab[i] = RUN_STOPPED;
            nxt[i] = NIL;
            prv[i] = NIL;
        end
        for (int i = 0; i < 2*LEVELS; i++) begin
            head[i] = NIL;
            tail[i] = NIL;
        end
        running = NIL;
    endfunction

    function automatic sched_result_t schedule(op_t op, int pid, logic [1:0] pr);
        sched_result_t r;
        int pick;
        r = '{status: 1'b1, pid: pid[5:0], prio: 2'd0, first: 1'b0};
        if (op == OP_RELEASE) begin
            if (valid_task(running)) begin
                queue_task(1, running);
                run_tab[running] = RUN_READY;
            end
            pick = take_highest_ready();
            if (!valid_task(pick)) begin
                for (int i = 0; i < LEVELS; i++) begin
                    head[i] = head[LEVELS+i];
                    tail[i] = tail[LEVELS+i];
                    head[LEVELS+i] = NIL;
                    tail[LEVELS+i] = NIL;
                end
                for (int i = 0; i < PROCESS_COUNT; i++)
                    if (tag_tab[i] == TAG_DONE) tag_tab[i] = TAG_READY;
                pick = take_highest_ready();
            end
            if (valid_task(pick)) begin
                r.first = (run_tab[pick] == RUN_STOPPED);
                run_tab[pick] = RUN_RUNNING;
                running = pick;
                r.status = 1'b0;
                r.pid = pick[5:0];
                r.prio = prio_tab[pick];
            end else begin
                running = NIL;
            end
        end else if (valid_task(pid)) begin
            if (op == OP_ADMIT) begin
                if (tag_tab[pid] == TAG_NONE && running != pid) begin
                    prio_tab[pid] = pr;
                    run_tab[pid] = RUN_STOPPED;
                    queue_task(0, pid);
                    r.status = 1'b0;
                    r.prio = pr;
                end
            end else if (op == OP_SETPRI) begin
                if (pid != 0) begin
                    if (running == pid || tag_tab[pid] == TAG_NONE) begin
                        prio_tab[pid] = pr;
                    end else begin
                        int set;
                        set = (tag_tab[pid] == TAG_DONE) ? 1 : 0;
                        dequeue_task(pid);
                        prio_tab[pid] = pr;
                        queue_task(set, pid);
                    end
                    r.status = 1'b0;
                    r.prio = pr;
                end
            end else begin
                r.status = 1'b0;
                r.prio = prio_tab[pid];
            end
        end
        return r;
    endfunction

    assign pending = awaited_results.size();

    always @(posedge aclk) begin
        sched_result_t want;
        if (!aresetn) begin
            clear_tables();
            awaited_results.delete();
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                awaited_results.push_back(schedule(op_t'(s_operation), int'(s_pid),
                                                   s_priority_req));
            if (m_valid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("Unexpected result: status %0d pid %0d prio %0d first %0d",
                                 m_status, m_pid_out, m_priority_out, m_first_start);
                    fail_count <= fail_count + 1;
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== m_status || want.pid !== m_pid_out ||
                        want.prio !== m_priority_out || want.first !== m_first_start) begin
                        if (fail_count < 10)
                            $display({"Mismatch: expected status %0d pid %0d prio %0d ",
                                      "first %0d, got %0d %0d %0d %0d"},
                                     want.status, want.pid, want.prio, want.first,
                                     m_status, m_pid_out, m_priority_out, m_first_start);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== verif/tb_priority_ready_done_scheduler_top.sv =====
// Testbench for the four-level priority scheduler. The top drives requests
// onto the s_ channel and collects results on the m_ channel; a separate
// checker keeps its own copy of the task tables, predicts each result and
// counts mismatches, which the top turns into the final verdict.
module tb_priority_ready_done_scheduler_top;
    import prds_pkg::*;

    localparam int PROCESS_COUNT = 8;
    localparam int STALL_LIMIT   = 2000;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [1:0] s_operation = OP_ADMIT;
    logic [5:0] s_pid = '0;
    logic [1:0] s_priority_req = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_status;
    logic [5:0] m_pid_out;
    logic [1:0] m_priority_out;
    logic       m_first_start;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    int         hold_cycles = 0;
    bit         stall_quiet = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    priority_ready_done_scheduler_top #(.PROCESS_COUNT(PROCESS_COUNT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_pid(s_pid), .s_priority_req(s_priority_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_pid_out(m_pid_out), .m_priority_out(m_priority_out),
        .m_first_start(m_first_start)
    );

    prds_checker #(.PROCESS_COUNT(PROCESS_COUNT)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_operation(s_operation),
        .s_pid(s_pid), .s_priority_req(s_priority_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_pid_out(m_pid_out), .m_priority_out(m_priority_out),
        .m_first_start(m_first_start),
        .fail_count(fail_count), .pending(pending)
    );

    // Mostly short gaps, occasionally a long one; phases of no gaps at all
    // are produced by the caller's quiet flag.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Present one request and hold it until the scheduler takes it. The
    // ready line is sampled at the falling edge, so the rising edge that
    // follows is the accepting one.
    task automatic send_request(op_t op, logic [5:0] pid, logic [1:0] pr, bit quiet);
        int gap;
        gap = quiet ? 0 : gap_length();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_pid <= pid;
        s_priority_req <= pr;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
    endtask

    // Task numbers mostly within the table, with the odd one beyond it so
    // that every pid bit is exercised.
    function automatic logic [5:0] pick_pid();
        if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, PROCESS_COUNT - 1));
    endfunction

    // The receiver stalls at random, now and then for a long stretch,
    // except during quiet stretches.
    always @(posedge aclk) begin
        if (!aresetn || stall_quiet) begin
            m_ready <= 1'b1;
            hold_cycles <= 0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if ($urandom_range(0, 99) < 3) begin
            m_ready <= 1'b0;
            hold_cycles <= $urandom_range(8, 30);
        end else begin
            m_ready <= ($urandom_range(0, 99) < 70);
        end
    end

    // The watchdog counts cycles with no request or result accepted.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        op_t op;
        int  roll;
        bit  quiet;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening: releasing with nothing queued, admits at every
        // level including out-of-table and busy tasks, set on pid zero, on
        // the running task and on queued tasks, then enough releases to
        // force the done set to be swapped in and a task to be chosen again.
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_ADMIT, 6'd1, 2'd3, 1'b0);
        send_request(OP_ADMIT, 6'd2, 2'd0, 1'b0);
        send_request(OP_ADMIT, 6'd7, 2'd1, 1'b0);
        send_request(OP_ADMIT, 6'd63, 2'd2, 1'b0);
        send_request(OP_ADMIT, 6'd8, 2'd0, 1'b0);
        send_request(OP_ADMIT, 6'd2, 2'd1, 1'b0);
        send_request(OP_GETPRI, 6'd1, 2'd0, 1'b0);
        send_request(OP_GETPRI, 6'd63, 2'd3, 1'b0);
        send_request(OP_SETPRI, 6'd0, 2'd2, 1'b0);
        send_request(OP_SETPRI, 6'd1, 2'd0, 1'b0);
        send_request(OP_SETPRI, 6'd40, 2'd1, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_SETPRI, 6'd2, 2'd3, 1'b0);
        send_request(OP_SETPRI, 6'd5, 2'd2, 1'b0);
        send_request(OP_ADMIT, 6'd2, 2'd0, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_SETPRI, 6'd7, 2'd0, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_RELEASE, 6'd0, 2'd0, 1'b0);
        send_request(OP_GETPRI, 6'd2, 2'd0, 1'b0);

        // Random part: releases and admits dominate so that queues fill and
        // drain and the swap is taken often; set moves tasks about, get reads priorities.
        for (int n = 0; n < 1300; n++) begin
            if (n % 200 == 0) stall_quiet = ($urandom_range(0, 2) == 0);
            quiet = stall_quiet;
            roll = $urandom_range(0, 99);
            if (roll < 35) op = OP_ADMIT;
            else if (roll < 70) op = OP_RELEASE;
            else if (roll < 88) op = OP_SETPRI;
            else op = OP_GETPRI;
            send_request(op, pick_pid(), 2'($urandom_range(0, 3)), quiet);
        end
        s_valid <= 1'b0;
        stall_quiet = 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
